// ----- design/first_fit_allocator_with_compaction_core_defines.svh -----
// Assertion macros used by the checker file.
`ifndef FIRST_FIT_ALLOCATOR_WITH_COMPACTION_CORE_DEFINES_SVH
`define FIRST_FIT_ALLOCATOR_WITH_COMPACTION_CORE_DEFINES_SVH
// Clocked assertion, disabled while rst is high.
`define FFA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Assertion that also holds during reset.
`define FFA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- design/ffa_pkg.sv -----
// Package with constants, types and codes of the first-fit allocator.
package ffa_pkg;
   localparam int MaxCells   = 128;
   localparam int MaxHandles = 128;
   localparam int CellW      = $clog2(MaxCells);
   localparam int CellCntW   = $clog2(MaxCells + 1);
   localparam int HndW       = $clog2(MaxHandles);
   localparam int HndCntW    = $clog2(MaxHandles + 1);
   localparam int SumW       = 17;

   localparam logic [1:0] OpAlloc = 2'd0;
   localparam logic [1:0] OpErase = 2'd1;

   localparam logic [2:0] StAlloc   = 3'd0;
   localparam logic [2:0] StNull    = 3'd1;
   localparam logic [2:0] StErased  = 3'd2;
   localparam logic [2:0] StIllegal = 3'd3;
   localparam logic [2:0] StDefrag  = 3'd4;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_MARK, S_ERD, S_CLEAR, S_DSEL, S_DWAIT, S_DPLACE, S_FILL, S_DONE
   } state_type;
endpackage

// ----- design/ffa_ram.sv -----
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module ffa_ram #(
   parameter int Width = 8,
   parameter int Depth = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- design/first_fit_allocator_with_compaction_core.sv -----
// Top level: first-fit cell allocator with compaction, one shared counter unit.
// Allocate scans cells one a cycle.
// busy is high from the accepted start until the result strobe; one item at a time.
// Results are strobed for one cycle and cannot be stalled by the receiver.
// Synchronous active-high reset clears the cell map, live bits and the handle counter.
module first_fit_allocator_with_compaction_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_operation,
   input  logic [7:0] req_block_size,
   input  logic [7:0] req_erase_handle,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   output logic       rsp_valid,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_new_handle
);
   import ffa_pkg::*;

   // Control state.
   state_type state_ff, state_in;
   logic [7:0] cells_ff;
   logic [MaxCells-1:0] busy_map_ff;
   logic [MaxHandles-1:0] live_ff;
   logic [HndCntW-1:0] issued_ff;
   // Working registers.
   logic [1:0] op_ff;
   logic [7:0] len_ff, hnd_ff;
   logic [SumW-1:0] idx_ff;      // shared counter: scan position, mark/clear offset, walk index, fill address
   logic [8:0] run_ff;           // length of current free run
   logic [SumW-1:0] now_ff;      // next compacted address
   logic [HndW-1:0] best_ff;     // defrag: chosen handle
   logic [8:0] best_start_ff;    // 256 means none
   logic [MaxHandles-1:0] done_ff; // defrag: already placed
   logic [SumW-1:0] base_ff;
   logic [2:0] st_ff;
   logic [7:0] nh_ff;

   logic [CellCntW-1:0] eff;
   assign eff = (cells_ff > 8'(MaxCells)) ? CellCntW'(MaxCells) : CellCntW'(cells_ff);

   // Start and length stores: start RAM and length RAM.
   logic st_we, ln_we;
   logic [HndW-1:0] st_wa, rd_a;
   logic [7:0] st_wd, st_rd, ln_rd;
   ffa_ram #(.Width(8), .Depth(MaxHandles)) u_start (
      .clock(clock), .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd),
      .rd_addr(rd_a), .rd_data(st_rd));
   ffa_ram #(.Width(8), .Depth(MaxHandles)) u_len (
      .clock(clock), .wr_en(ln_we), .wr_addr(st_wa), .wr_data(len_ff),
      .rd_addr(rd_a), .rd_data(ln_rd));

   logic [HndW-1:0] walk_h;
   assign walk_h = idx_ff[HndW-1:0];
   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);
   assign rsp_status = st_ff;
   assign rsp_new_handle = nh_ff;

   // Defrag selection: walk issued handles reading start, keep smallest not done.
   // RAM read is registered, so handle idx-1 data appears while idx is issued.
   logic [HndW-1:0] prev_h;
   assign prev_h = walk_h - HndW'(1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (start) begin
            if (req_operation == OpAlloc) begin
               if (issued_ff >= HndCntW'(MaxHandles) || eff == '0 ||
                   {1'b0, req_block_size} > 9'(eff)) state_in = S_DONE;
               else if (req_block_size == 8'd0) state_in = S_MARK;
               else state_in = S_SCAN;
            end else if (req_operation == OpErase) begin
               if (req_erase_handle == 8'd0 ||
                   {1'b0, req_erase_handle} > 9'(issued_ff) ||
                   !live_ff[HndW'(req_erase_handle - 8'd1)]) state_in = S_DONE;
               else state_in = S_ERD;
            end else state_in = S_DSEL;
         end
         S_SCAN: begin
            if (idx_ff >= SumW'(eff)) state_in = S_DONE;
            else if (!busy_map_ff[idx_ff[CellW-1:0]] &&
                     run_ff + 9'd1 == {1'b0, len_ff}) state_in = S_MARK;
         end
         S_MARK:  if (idx_ff >= SumW'(len_ff)) state_in = S_DONE;
         S_ERD:   state_in = S_CLEAR;
         S_CLEAR: if (idx_ff >= SumW'(ln_rd)) state_in = S_DONE;
         S_DSEL:  state_in = S_DWAIT;
         S_DWAIT: if (idx_ff > SumW'(issued_ff)) state_in = S_DPLACE;
         S_DPLACE: state_in = (best_start_ff[8]) ? S_FILL : S_DSEL;
         S_FILL:  if (idx_ff >= SumW'(MaxCells) - SumW'(1)) state_in = S_DONE;
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      st_we = 1'b0; ln_we = 1'b0;
      st_wa = hnd_ff[HndW-1:0]; st_wd = base_ff[7:0];
      rd_a = hnd_ff[HndW-1:0];
      if (state_ff == S_MARK && idx_ff == '0) begin
         st_we = 1'b1; ln_we = 1'b1; st_wa = issued_ff[HndW-1:0];
      end
      if (state_ff == S_DPLACE && !best_start_ff[8]) begin
         st_we = 1'b1; st_wa = best_ff; st_wd = now_ff[7:0];
      end
      if (state_ff == S_DWAIT || state_ff == S_DSEL) rd_a = walk_h;
      if (state_ff == S_DPLACE) rd_a = best_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; cells_ff <= 8'd128;
         busy_map_ff <= '0; live_ff <= '0; issued_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) cells_ff <= csr_wr_data;
         unique case (state_ff)
            S_IDLE: if (start) begin
               op_ff <= req_operation; len_ff <= req_block_size;
               hnd_ff <= req_erase_handle - 8'd1;
               idx_ff <= '0; run_ff <= '0; base_ff <= '0; now_ff <= '0;
               done_ff <= '0; best_start_ff <= 9'h100; nh_ff <= '0;
               st_ff <= (req_operation == OpAlloc) ? StNull :
                        (req_operation == OpErase) ? StIllegal : StDefrag;
            end
            S_SCAN: begin
               if (busy_map_ff[idx_ff[CellW-1:0]]) begin
                  run_ff <= '0; base_ff <= idx_ff + SumW'(1);
                  idx_ff <= idx_ff + SumW'(1);
               end else if (run_ff + 9'd1 == {1'b0, len_ff}) idx_ff <= '0;
               else begin
                  run_ff <= run_ff + 9'd1; idx_ff <= idx_ff + SumW'(1);
               end
            end
            S_MARK: begin
               if (idx_ff >= SumW'(len_ff)) begin
                  live_ff[issued_ff[HndW-1:0]] <= 1'b1;
                  issued_ff <= issued_ff + HndCntW'(1);
                  st_ff <= StAlloc;
                  nh_ff <= 8'(issued_ff + HndCntW'(1));
               end else begin
                  if (base_ff + idx_ff < SumW'(MaxCells))
                     busy_map_ff[CellW'(base_ff + idx_ff)] <= 1'b1;
                  idx_ff <= idx_ff + SumW'(1);
               end
            end
            S_ERD: idx_ff <= '0;
            S_CLEAR: begin
               if (idx_ff >= SumW'(ln_rd)) begin
                  live_ff[hnd_ff[HndW-1:0]] <= 1'b0; st_ff <= StErased;
               end else begin
                  if (SumW'(st_rd) + idx_ff < SumW'(MaxCells))
                     busy_map_ff[CellW'(SumW'(st_rd) + idx_ff)] <= 1'b0;
                  idx_ff <= idx_ff + SumW'(1);
               end
            end
            S_DSEL: begin
               idx_ff <= SumW'(1); best_start_ff <= 9'h100;
            end
            S_DWAIT: begin
               // Compare the start of handle idx-1 against the best so far.
               if (live_ff[prev_h] && !done_ff[prev_h] &&
                   {1'b0, st_rd} < best_start_ff) begin
                  best_start_ff <= {1'b0, st_rd}; best_ff <= prev_h;
               end
               idx_ff <= idx_ff + SumW'(1);
            end
            S_DPLACE: begin
               idx_ff <= '0;
               if (!best_start_ff[8]) done_ff[best_ff] <= 1'b1;
            end
            S_FILL: begin
               busy_map_ff[idx_ff[CellW-1:0]] <= (idx_ff < now_ff);
               idx_ff <= idx_ff + SumW'(1);
            end
            default: ;
         endcase
         // Length of the placed block arrives in the cycle after DPLACE, in DSEL.
         if (state_ff == S_DSEL && op_ff[1] && best_start_ff != 9'h100 &&
             idx_ff == '0 && done_ff != '0)
            now_ff <= now_ff + SumW'(ln_rd);
      end
   end
endmodule

// ----- design/ffa_checker.sv -----
// Port-level checker for the allocator, bound to the top level.
`include "first_fit_allocator_with_compaction_core_defines.svh"
module ffa_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [2:0] rsp_status,
   input logic [7:0] rsp_new_handle
);
   import ffa_pkg::*;
   `FFA_ASSERT(a_accept_busy, clock, reset, (start && !busy) |=> busy, "no busy after start")
   `FFA_ASSERT(a_one_strobe, clock, reset, rsp_valid |=> !rsp_valid, "double strobe")
   `FFA_ASSERT(a_handle_ok, clock, reset, (rsp_valid && rsp_status != StAlloc) |-> rsp_new_handle == 8'd0, "stray handle")
   `FFA_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !busy, "busy after reset")
endmodule

bind first_fit_allocator_with_compaction_core ffa_checker u_ffa_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_new_handle(rsp_new_handle));
